// ===== hw/rtl/brr_pkg.sv =====
// ----------------------------------------------------------------------------
// brr_pkg: shared types and constants of the bilinear RGB resizer
// Holds the request and response payload structs, the register indexes and
// a helper that picks one colour channel out of a stored pixel.
// ----------------------------------------------------------------------------
package brr_pkg;

   localparam int CHAN_W  = 16;
   localparam int POS_W   = 12;
   localparam int SIZE_W  = 9;
   localparam int STEP_W  = 24;
   localparam int CSR_W   = 24;
   localparam int CSR_IDX_W = 2;
   localparam int PIX_W   = 3 * CHAN_W;

   // Request kinds.
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_X        = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_Y        = 2'd3;

   // Colour channel codes.
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef struct packed {
      logic              req_type;
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } brr_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
   } brr_rsp_type;

   // A stored pixel keeps red in the top third and blue in the bottom third.
   function automatic logic [CHAN_W-1:0] pick_channel(input logic [PIX_W-1:0] pix,
                                                      input logic [1:0] chan);
      logic [CHAN_W-1:0] val;
      begin
         case (chan)
            CH_RED:   val = pix[3*CHAN_W-1:2*CHAN_W];
            CH_GREEN: val = pix[2*CHAN_W-1:CHAN_W];
            CH_BLUE:  val = pix[CHAN_W-1:0];
            default:  val = '0;
         endcase
         return val;
      end
   endfunction

endpackage

// ===== hw/rtl/brr_store.sv =====
// ----------------------------------------------------------------------------
// brr_store: single-port frame store
// One access per cycle: a write when wr_en is high, otherwise a read whose
// data appears registered in the following cycle.
// ----------------------------------------------------------------------------
module brr_store #(
   parameter int ADDR_W = 16
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          addr,
   input  logic [brr_pkg::PIX_W-1:0]  wr_data,
   output logic [brr_pkg::PIX_W-1:0]  rd_data
);
   import brr_pkg::*;

   logic [PIX_W-1:0] store_mem [2**ADDR_W];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[addr] <= wr_data;
      end
      rd_data_ff <= store_mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/brr_mul.sv =====
// ----------------------------------------------------------------------------
// brr_mul: shared registered multiplier
// Signed 34 by 17 bit product, registered, so each operation's result is
// available in the cycle after its operands are presented.
// ----------------------------------------------------------------------------
module brr_mul (
   input  logic               clock,
   input  logic signed [33:0] op_a,
   input  logic signed [16:0] op_b,
   output logic signed [50:0] prod
);
   logic signed [50:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= 51'(op_a * op_b);
   end

   assign prod = prod_ff;

endmodule

// ===== hw/rtl/bilinear_rgb_resize.sv =====
// ----------------------------------------------------------------------------
// bilinear_rgb_resize: corner-aligned bilinear RGB resizer
// Loads source pixels into a frame store and answers destination-pixel
// queries with a four-tap blend per channel, rounded to nearest.
// ----------------------------------------------------------------------------
// Usage. The request channel (req_valid, req_ready, req_data) carries two
// kinds of transfer. A load writes one 48-bit RGB pixel into the frame store
// at its source column and row; loads outside the configured source size are
// dropped. A load produces no response and the block stays idle, so loads
// may be issued back to back. A query names a destination column and row and
// yields exactly one response transfer on rsp_valid, rsp_ready, rsp_data.
// A query occupies the block from its acceptance to rsp_valid: the MAPX, MAPY
// and ADDR states map the coordinates with two multiplies, FETCH reads the
// four neighbours through the single store port, BLEND mixes three channels on
// the one shared multiplier (three products per channel plus a final round)
// and DONE moves the result into the output register. req_ready is low during
// that time and rises together with rsp_valid, so a new query is accepted only
// after the previous result has entered the output register. The output
// register lets the next load or query be accepted while a response still
// waits; a query whose result finds that register full holds until the
// receiver takes the earlier one. The csr_ port writes the size and step
// registers; write it only while the block is idle. Synchronous reset returns
// the registers to their defaults and drops any pending response; the store
// contents are undefined until loaded.
// ----------------------------------------------------------------------------
module bilinear_rgb_resize #(
   parameter int MAX_SRC_WIDTH  = 256,
   parameter int MAX_SRC_HEIGHT = 256,
   parameter int MAX_DST_DIM    = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  brr_pkg::brr_req_type            req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output brr_pkg::brr_rsp_type            rsp_data,
   input  logic                            csr_wr_en,
   input  logic [brr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [brr_pkg::CSR_W-1:0]       csr_wdata
);
   import brr_pkg::*;

   localparam int XW  = $clog2(MAX_SRC_WIDTH);
   localparam int YW  = $clog2(MAX_SRC_HEIGHT);
   localparam int AW  = XW + YW;
   localparam int SWW = $clog2(MAX_SRC_WIDTH + 1);
   localparam int SHW = $clog2(MAX_SRC_HEIGHT + 1);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_MAPX  = 7'b0000010,
      S_MAPY  = 7'b0000100,
      S_ADDR  = 7'b0001000,
      S_FETCH = 7'b0010000,
      S_BLEND = 7'b0100000,
      S_DONE  = 7'b1000000
   } brr_state_type;

   // Control registers.
   brr_state_type        state_ff, state_in;
   logic [3:0]           cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SIZE_W-1:0]    src_width_ff, src_height_ff;
   logic [STEP_W-1:0]    step_x_ff, step_y_ff;

   // Payload registers.
   logic [POS_W-1:0]     pos_x_ff, pos_y_ff;
   logic [XW-1:0]        x0_ff, x1_ff;
   logic [YW-1:0]        y0_ff, y1_ff;
   logic [CHAN_W-1:0]    fx_ff, fy_ff;
   logic [PIX_W-1:0]     p00_ff, p10_ff, p01_ff, p11_ff;
   logic [31:0]          h0_ff, h1_ff;
   logic [CHAN_W-1:0]    red_ff, green_ff, blue_ff;
   brr_rsp_type          rsp_data_ff;

   logic                 req_fire;
   logic                 load_inside;
   logic                 store_wr_en;
   logic [AW-1:0]        store_addr;
   logic [PIX_W-1:0]     store_rd_data;

   logic [SWW-1:0]       src_w, last_x;
   logic [SHW-1:0]       src_h, last_y;
   logic [POS_W-1:0]     pos_x_c, pos_y_c;

   logic signed [33:0]   mul_a;
   logic signed [16:0]   mul_b;
   logic signed [50:0]   prod;

   logic [19:0]          whole;
   logic [XW-1:0]        map_x0, map_x1;
   logic [YW-1:0]        map_y0, map_y1;

   logic [1:0]           chan;
   logic [1:0]           tick;
   logic [1:0]           prev_chan;
   logic signed [16:0]   diff_top, diff_bot;
   logic signed [32:0]   diff_vert;
   logic signed [50:0]   lerp_top, lerp_bot, acc;

   // ---------------------------------------------------------------------
   // Effective source size: zero reads as one, oversize saturates.
   // ---------------------------------------------------------------------
   always_comb begin
      if (src_width_ff == '0) begin
         src_w = SWW'(1);
      end else if (32'(src_width_ff) > MAX_SRC_WIDTH) begin
         src_w = SWW'(MAX_SRC_WIDTH);
      end else begin
         src_w = SWW'(src_width_ff);
      end
      if (src_height_ff == '0) begin
         src_h = SHW'(1);
      end else if (32'(src_height_ff) > MAX_SRC_HEIGHT) begin
         src_h = SHW'(MAX_SRC_HEIGHT);
      end else begin
         src_h = SHW'(src_height_ff);
      end
      last_x = src_w - SWW'(1);
      last_y = src_h - SHW'(1);
   end

   // Destination coordinates beyond the supported range are pinned to it.
   assign pos_x_c = (32'(pos_x_ff) >= MAX_DST_DIM) ? POS_W'(MAX_DST_DIM - 1) : pos_x_ff;
   assign pos_y_c = (32'(pos_y_ff) >= MAX_DST_DIM) ? POS_W'(MAX_DST_DIM - 1) : pos_y_ff;

   // ---------------------------------------------------------------------
   // Handshake and frame store access.
   // ---------------------------------------------------------------------
   assign req_ready   = (state_ff == S_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign load_inside = (32'(req_data.pos_x) < 32'(src_w)) &&
                        (32'(req_data.pos_y) < 32'(src_h));
   assign store_wr_en = req_fire && (req_data.req_type == REQ_LOAD) && load_inside;

   always_comb begin
      store_addr = {YW'(req_data.pos_y), XW'(req_data.pos_x)};
      if (state_ff == S_FETCH) begin
         case (cnt_ff)
            4'd0:    store_addr = {y0_ff, x0_ff};
            4'd1:    store_addr = {y0_ff, x1_ff};
            4'd2:    store_addr = {y1_ff, x0_ff};
            default: store_addr = {y1_ff, x1_ff};
         endcase
      end
   end

   brr_store #(
      .ADDR_W (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .addr    (store_addr),
      .wr_data ({req_data.red_in, req_data.green_in, req_data.blue_in}),
      .rd_data (store_rd_data)
   );

   // ---------------------------------------------------------------------
   // Coordinate mapping from the registered product. In MAPY the product
   // holds the column mapping and in ADDR the row mapping. The integer part
   // saturates to the last column or row and the neighbour stops at it.
   // ---------------------------------------------------------------------
   assign whole = prod[35:16];

   always_comb begin
      map_x0 = (whole > 20'(last_x)) ? XW'(last_x) : XW'(whole);
      map_x1 = (32'(map_x0) >= 32'(last_x)) ? map_x0 : map_x0 + XW'(1);
      map_y0 = (whole > 20'(last_y)) ? YW'(last_y) : YW'(whole);
      map_y1 = (32'(map_y0) >= 32'(last_y)) ? map_y0 : map_y0 + YW'(1);
   end

   // ---------------------------------------------------------------------
   // Blend schedule. Each channel takes these ticks on the multiplier, in order:
   // top row difference times fx, bottom row difference times fx, an idle
   // tick while the bottom row sum settles, then vertical difference times
   // fy. The rounded result of a channel is taken on the first tick of the
   // next one, so a final tick after the last channel finishes blue.
   // ---------------------------------------------------------------------
   assign chan      = cnt_ff[3:2];
   assign tick      = cnt_ff[1:0];
   assign prev_chan = chan - 2'd1;

   assign diff_top  = $signed({1'b0, pick_channel(p10_ff, chan)}) -
                      $signed({1'b0, pick_channel(p00_ff, chan)});
   assign diff_bot  = $signed({1'b0, pick_channel(p11_ff, chan)}) -
                      $signed({1'b0, pick_channel(p01_ff, chan)});
   assign diff_vert = $signed({1'b0, h1_ff}) - $signed({1'b0, h0_ff});

   assign lerp_top = $signed({19'b0, pick_channel(p00_ff, chan), 16'b0}) + prod;
   assign lerp_bot = $signed({19'b0, pick_channel(p01_ff, chan), 16'b0}) + prod;
   assign acc      = $signed({3'b0, h0_ff, 16'b0}) + prod + 51'sd2147483648;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MAPX: begin
            mul_a = $signed({10'b0, step_x_ff});
            mul_b = $signed({5'b0, pos_x_c});
         end
         S_MAPY: begin
            mul_a = $signed({10'b0, step_y_ff});
            mul_b = $signed({5'b0, pos_y_c});
         end
         S_BLEND: begin
            if (chan != 2'd3) begin
               case (tick)
                  2'd0: begin
                     mul_a = {{17{diff_top[16]}}, diff_top};
                     mul_b = $signed({1'b0, fx_ff});
                  end
                  2'd1: begin
                     mul_a = {{17{diff_bot[16]}}, diff_bot};
                     mul_b = $signed({1'b0, fx_ff});
                  end
                  2'd3: begin
                     mul_a = {diff_vert[32], diff_vert};
                     mul_b = $signed({1'b0, fy_ff});
                  end
                  default: begin
                     mul_a = '0;
                     mul_b = '0;
                  end
               endcase
            end
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   brr_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   // ---------------------------------------------------------------------
   // Sequencer.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_data.req_type == REQ_QUERY)) begin
               state_in = S_MAPX;
            end
         end
         S_MAPX: begin
            state_in = S_MAPY;
         end
         S_MAPY: begin
            state_in = S_ADDR;
         end
         S_ADDR: begin
            state_in = S_FETCH;
            cnt_in   = 4'd0;
         end
         S_FETCH: begin
            if (cnt_ff == 4'd4) begin
               state_in = S_BLEND;
               cnt_in   = 4'd0;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         S_BLEND: begin
            if (cnt_ff == 4'd12) begin
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         src_width_ff  <= SIZE_W'(256);
         src_height_ff <= SIZE_W'(256);
         step_x_ff     <= '0;
         step_y_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SOURCE_WIDTH:  src_width_ff  <= csr_wdata[SIZE_W-1:0];
               CSR_SOURCE_HEIGHT: src_height_ff <= csr_wdata[SIZE_W-1:0];
               CSR_STEP_X:        step_x_ff     <= csr_wdata[STEP_W-1:0];
               CSR_STEP_Y:        step_y_ff     <= csr_wdata[STEP_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Datapath registers; no reset needed.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         pos_x_ff <= req_data.pos_x;
         pos_y_ff <= req_data.pos_y;
      end
      if (state_ff == S_MAPY) begin
         x0_ff <= map_x0;
         x1_ff <= map_x1;
         fx_ff <= (src_w == SWW'(1)) ? '0 : prod[15:0];
      end
      if (state_ff == S_ADDR) begin
         y0_ff <= map_y0;
         y1_ff <= map_y1;
         fy_ff <= (src_h == SHW'(1)) ? '0 : prod[15:0];
      end
      if (state_ff == S_FETCH) begin
         case (cnt_ff)
            4'd1:    p00_ff <= store_rd_data;
            4'd2:    p10_ff <= store_rd_data;
            4'd3:    p01_ff <= store_rd_data;
            4'd4:    p11_ff <= store_rd_data;
            default: begin
            end
         endcase
      end
      if (state_ff == S_BLEND) begin
         case (tick)
            2'd0: begin
               if (chan != CH_RED) begin
                  case (prev_chan)
                     CH_RED:   red_ff   <= acc[47:32];
                     CH_GREEN: green_ff <= acc[47:32];
                     default:  blue_ff  <= acc[47:32];
                  endcase
               end
            end
            2'd1:    h0_ff <= lerp_top[31:0];
            2'd2:    h1_ff <= lerp_bot[31:0];
            default: begin
            end
         endcase
      end
      if ((state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready)) begin
         rsp_data_ff.red_out   <= red_ff;
         rsp_data_ff.green_out <= green_ff;
         rsp_data_ff.blue_out  <= blue_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   a_query_starts_map: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_data.req_type == REQ_QUERY)) |=> (state_ff == S_MAPX))
      else $error("accepted query did not start coordinate mapping");

   a_done_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE) && rsp_valid_ff && !rsp_ready) |=> (state_ff == S_DONE))
      else $error("finished query overwrote a waiting response");

   a_neighbours_ordered: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FETCH) |-> ((x0_ff <= x1_ff) && (y0_ff <= y1_ff)))
      else $error("neighbour index below base index");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("response raised outside the completion state");

endmodule
